// File: rtl/core/igmpgt_pkg.sv
// Package: shared types, codes and defaults for the IGMP group table.
package igmpgt_pkg;

    localparam int DEF_NUM_ENTRIES = 32;
    localparam int DEF_PORT_BITS   = 4;
    localparam int FQ_DEPTH        = 2;
    localparam int RQ_DEPTH        = 2;
    localparam int ADDR_W          = 3;

    localparam logic [15:0] LIFETIME_RESET   = 16'd260;
    localparam logic        REG_IDX_LIFETIME = 1'b0;
    localparam logic [5:0]  EXP_MAX          = 6'd63;

    typedef enum logic [1:0] {
        OP_JOIN   = 2'd0,
        OP_LEAVE  = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_TICK   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_MATCH   = 3'd0,
        ST_ADDED   = 3'd1,
        ST_FULL    = 3'd2,
        ST_NOMATCH = 3'd3,
        ST_REMOVED = 3'd4
    } t_status;

    typedef struct packed {
        t_op         op;
        logic [3:0]  port;
        logic [31:0] group;
    } t_cmd;

    typedef struct packed {
        logic        member;
        t_status     status;
        logic [5:0]  expired;
    } t_result;

endpackage

// File: rtl/core/igmpgt_front.sv
// Front end: decodes incoming transactions and queues them for the table engine.
module igmpgt_front
    import igmpgt_pkg::*;
#(
    parameter int PORT_BITS = DEF_PORT_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [1:0]  i_func,
    input  logic [3:0]  i_port,
    input  logic [31:0] i_group_addr,
    output logic        o_cmd_valid,
    input  logic        i_cmd_pop,
    output t_cmd        o_cmd
);

    localparam int QW = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;
    localparam logic [3:0] PORT_MASK =
        (PORT_BITS >= 4) ? 4'hF : 4'((1 << PORT_BITS) - 1);

    t_cmd          r_q [FQ_DEPTH];
    logic [QW-1:0] r_wp, n_wp;
    logic [QW-1:0] r_rp, n_rp;
    logic [QW:0]   r_cnt, n_cnt;
    t_cmd          cmd_in;
    logic          do_push;
    logic          do_pop;

    assign o_full      = (r_cnt == (QW+1)'(FQ_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];
    assign do_push     = i_push && !o_full;
    assign do_pop      = i_cmd_pop && o_cmd_valid;

    always_comb begin
        cmd_in.op    = t_op'(i_func);
        cmd_in.port  = i_port & PORT_MASK;
        cmd_in.group = i_group_addr;
    end

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == QW'(FQ_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == QW'(FQ_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp] <= cmd_in;
        end
    end

endmodule

// File: rtl/core/igmpgt_back.sv
// Back end: table memory and the scan engine that carries out each operation.
module igmpgt_back
    import igmpgt_pkg::*;
#(
    parameter int NUM_ENTRIES = DEF_NUM_ENTRIES,
    parameter int PORT_BITS   = DEF_PORT_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_lifetime,
    input  logic        i_cmd_valid,
    output logic        o_cmd_pop,
    input  t_cmd        i_cmd,
    input  logic        i_res_full,
    output logic        o_res_push,
    output t_result     o_res,
    output logic        o_clearing
);

    localparam int IW = $clog2(NUM_ENTRIES);
    localparam int EW = 1 + PORT_BITS + 32 + 16;
    localparam logic [IW:0] CNT_END  = (IW+1)'(NUM_ENTRIES);
    localparam logic [IW:0] CNT_LAST = (IW+1)'(NUM_ENTRIES - 1);

    typedef enum logic [3:0] {
        BS_CLEAR = 4'b0001,
        BS_IDLE  = 4'b0010,
        BS_SCAN  = 4'b0100,
        BS_APPLY = 4'b1000
    } t_bstate;

    t_bstate        r_state, n_state;
    logic [IW:0]    r_cnt, n_cnt;
    logic           r_chk_vld, n_chk_vld;
    logic [IW-1:0]  r_chk_idx;
    logic           r_hit_found, n_hit_found;
    logic [IW-1:0]  r_hit_idx, n_hit_idx;
    logic           r_free_found, n_free_found;
    logic [IW-1:0]  r_free_idx, n_free_idx;
    logic [5:0]     r_expired, n_expired;
    t_cmd           r_cmd;

    logic [EW-1:0]  r_mem [NUM_ENTRIES];
    logic [EW-1:0]  r_rdata;
    logic           mem_we;
    logic [IW-1:0]  mem_waddr;
    logic [EW-1:0]  mem_wdata;

    logic                 rd_valid;
    logic [PORT_BITS-1:0] rd_port;
    logic [31:0]          rd_group;
    logic [15:0]          rd_timer;
    logic                 rd_match;
    logic [PORT_BITS+3:0] port_wide;
    logic [PORT_BITS-1:0] cmd_port;
    logic [EW-1:0]        new_entry;

    assign rd_valid  = r_rdata[EW-1];
    assign rd_port   = r_rdata[48 +: PORT_BITS];
    assign rd_group  = r_rdata[47:16];
    assign rd_timer  = r_rdata[15:0];
    assign port_wide = {{PORT_BITS{1'b0}}, r_cmd.port};
    assign cmd_port  = port_wide[PORT_BITS-1:0];
    assign rd_match  = rd_valid && (rd_port == cmd_port) && (rd_group == r_cmd.group);
    assign new_entry = {1'b1, cmd_port, r_cmd.group, i_lifetime};
    assign o_clearing = (r_state == BS_CLEAR);

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_chk_vld    = 1'b0;
        n_hit_found  = r_hit_found;
        n_hit_idx    = r_hit_idx;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_expired    = r_expired;
        mem_we       = 1'b0;
        mem_waddr    = r_chk_idx;
        mem_wdata    = '0;
        o_cmd_pop    = 1'b0;
        o_res_push   = 1'b0;
        o_res        = '0;
        unique case (r_state)
            BS_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_cnt[IW-1:0];
                if (r_cnt == CNT_LAST) begin
                    n_cnt   = '0;
                    n_state = BS_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            BS_IDLE: begin
                if (i_cmd_valid && !i_res_full) begin
                    o_cmd_pop    = 1'b1;
                    n_cnt        = '0;
                    n_hit_found  = 1'b0;
                    n_free_found = 1'b0;
                    n_expired    = '0;
                    n_state      = BS_SCAN;
                end
            end
            BS_SCAN: begin
                if (r_cnt != CNT_END) begin
                    n_cnt     = r_cnt + 1'b1;
                    n_chk_vld = 1'b1;
                end
                if (r_chk_vld) begin
                    if (r_cmd.op == OP_TICK) begin
                        if (rd_valid) begin
                            mem_we = 1'b1;
                            if (rd_timer <= 16'd1) begin
                                mem_wdata = '0;
                                if (r_expired != EXP_MAX) begin
                                    n_expired = r_expired + 1'b1;
                                end
                            end else begin
                                mem_wdata = {rd_valid, rd_port, rd_group, rd_timer - 16'd1};
                            end
                        end
                    end else begin
                        if (rd_match && !r_hit_found) begin
                            n_hit_found = 1'b1;
                            n_hit_idx   = r_chk_idx;
                        end
                        if (!rd_valid && !r_free_found) begin
                            n_free_found = 1'b1;
                            n_free_idx   = r_chk_idx;
                        end
                    end
                end else if (r_cnt == CNT_END) begin
                    n_state = BS_APPLY;
                end
            end
            BS_APPLY: begin
                o_res_push = 1'b1;
                o_res.member = (r_cmd.op != OP_TICK) && r_hit_found;
                unique case (r_cmd.op)
                    OP_JOIN: begin
                        if (r_hit_found) begin
                            mem_we       = 1'b1;
                            mem_waddr    = r_hit_idx;
                            mem_wdata    = new_entry;
                            o_res.status = ST_MATCH;
                        end else if (r_free_found) begin
                            mem_we       = 1'b1;
                            mem_waddr    = r_free_idx;
                            mem_wdata    = new_entry;
                            o_res.status = ST_ADDED;
                        end else begin
                            o_res.status = ST_FULL;
                        end
                    end
                    OP_LEAVE: begin
                        if (r_hit_found) begin
                            mem_we       = 1'b1;
                            mem_waddr    = r_hit_idx;
                            mem_wdata    = '0;
                            o_res.status = ST_REMOVED;
                        end else begin
                            o_res.status = ST_NOMATCH;
                        end
                    end
                    OP_LOOKUP: begin
                        o_res.status = r_hit_found ? ST_MATCH : ST_NOMATCH;
                    end
                    OP_TICK: begin
                        o_res.status  = ST_MATCH;
                        o_res.expired = r_expired;
                    end
                endcase
                n_state = BS_IDLE;
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= BS_CLEAR;
            r_cnt        <= '0;
            r_chk_vld    <= 1'b0;
            r_hit_found  <= 1'b0;
            r_free_found <= 1'b0;
            r_expired    <= '0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_chk_vld    <= n_chk_vld;
            r_hit_found  <= n_hit_found;
            r_free_found <= n_free_found;
            r_expired    <= n_expired;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_idx  <= r_cnt[IW-1:0];
        r_hit_idx  <= n_hit_idx;
        r_free_idx <= n_free_idx;
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[r_cnt[IW-1:0]];
    end

endmodule

// File: rtl/core/igmpgt_resq.sv
// Result queue: holds finished results until the consumer pops them.
module igmpgt_resq
    import igmpgt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_res_push,
    input  t_result i_res,
    output logic    o_res_full,
    output logic    o_empty,
    input  logic    i_pop,
    output t_result o_res
);

    localparam int QW = (RQ_DEPTH > 1) ? $clog2(RQ_DEPTH) : 1;

    t_result       r_q [RQ_DEPTH];
    logic [QW-1:0] r_wp, n_wp;
    logic [QW-1:0] r_rp, n_rp;
    logic [QW:0]   r_cnt, n_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_res_full = (r_cnt == (QW+1)'(RQ_DEPTH));
    assign o_empty    = (r_cnt == '0);
    assign o_res      = r_q[r_rp];
    assign do_push    = i_res_push && !o_res_full;
    assign do_pop     = i_pop && !o_empty;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == QW'(RQ_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == QW'(RQ_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp] <= i_res;
        end
    end

endmodule

// File: rtl/core/igmp_group_table_with_aging_unit.sv
// Top level: IGMP group table with aging, register port and queue interfaces.
// Each transaction (join, leave, lookup or one-second tick) is carried out by a
// scan of the table memory, one entry per cycle through its single read port;
// a short input queue and a result queue decouple the engine from both
// neighbours. After reset a clearing pass writes every entry free, with full
// held high meanwhile; register writes are taken throughout.
module igmp_group_table_with_aging_unit
    import igmpgt_pkg::*;
#(
    parameter int NUM_ENTRIES = DEF_NUM_ENTRIES,
    parameter int PORT_BITS   = DEF_PORT_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              push,
    output logic              full,
    input  logic [1:0]        i_func,
    input  logic [3:0]        i_port,
    input  logic [31:0]       i_group_addr,
    output logic              empty,
    input  logic              pop,
    output logic              o_member,
    output logic [2:0]        o_status,
    output logic [5:0]        o_expired
);

    logic [15:0] r_lifetime;
    logic        front_full;
    logic        clearing;
    logic        cmd_valid;
    logic        cmd_pop;
    t_cmd        cmd;
    logic        res_full;
    logic        res_push;
    t_result     res_in;
    t_result     res_out;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_IDX_LIFETIME);
    assign prdata = (paddr[2] == REG_IDX_LIFETIME) ? {16'd0, r_lifetime} : 32'd0;
    assign full   = front_full || clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lifetime <= LIFETIME_RESET;
        end else if (cfg_wr) begin
            r_lifetime <= pwdata[15:0];
        end
    end

    igmpgt_front #(
        .PORT_BITS   (PORT_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push && !clearing),
        .o_full       (front_full),
        .i_func       (i_func),
        .i_port       (i_port),
        .i_group_addr (i_group_addr),
        .o_cmd_valid  (cmd_valid),
        .i_cmd_pop    (cmd_pop),
        .o_cmd        (cmd)
    );

    igmpgt_back #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .PORT_BITS   (PORT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_lifetime  (r_lifetime),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .i_cmd       (cmd),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in),
        .o_clearing  (clearing)
    );

    igmpgt_resq u_resq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_res_push (res_push),
        .i_res      (res_in),
        .o_res_full (res_full),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_res      (res_out)
    );

    assign o_member  = res_out.member;
    assign o_status  = res_out.status;
    assign o_expired = res_out.expired;

endmodule

// File: tb/igmp_group_table_with_aging_unit_tb.sv
// Testbench for the IGMP group table with aging: directed and random traffic vs a predictor.
module igmp_group_table_with_aging_unit_tb
    import igmpgt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM = DEF_NUM_ENTRIES;
    localparam int POOL_N = 48;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam logic [3:0] PORT_MASK = 4'((1 << DEF_PORT_BITS) - 1);
    localparam logic [ADDR_W-1:0] ADDR_LIFETIME = ADDR_W'(REG_IDX_LIFETIME) << 2;
    localparam logic [ADDR_W-1:0] ADDR_SPARE = ADDR_LIFETIME + 3'd4;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              push = 1'b0;
    logic              full;
    logic [1:0]        i_func = '0;
    logic [3:0]        i_port = '0;
    logic [31:0]       i_group_addr = '0;
    logic              empty;
    logic              pop = 1'b0;
    logic              o_member;
    logic [2:0]        o_status;
    logic [5:0]        o_expired;

    // predicted table contents
    logic        tbl_valid [NUM] = '{default: 1'b0};
    logic [31:0] tbl_group [NUM] = '{default: '0};
    logic [3:0]  tbl_port  [NUM] = '{default: '0};
    logic [15:0] tbl_timer [NUM] = '{default: '0};
    logic [15:0] tbl_lifetime = LIFETIME_RESET;

    t_result     pending_results[$];
    t_result     want;
    logic [3:0]  pool_port [POOL_N];
    logic [31:0] pool_grp  [POOL_N];
    int          send_idle_pct = 0;
    int          pop_stall_pct = 0;
    int          hold_left = 0;
    int          err_count = 0;
    int          cycle_count = 0;

    igmp_group_table_with_aging_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .push         (push),
        .full         (full),
        .i_func       (i_func),
        .i_port       (i_port),
        .i_group_addr (i_group_addr),
        .empty        (empty),
        .pop          (pop),
        .o_member     (o_member),
        .o_status     (o_status),
        .o_expired    (o_expired)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic t_result table_update(t_op op, logic [3:0] port_in, logic [31:0] grp);
        t_result     r;
        int          hit;
        logic        placed;
        logic [3:0]  port;
        r = '{member: 1'b0, status: ST_MATCH, expired: '0};
        port = port_in & PORT_MASK;
        hit = -1;
        placed = 1'b0;
        if (op == OP_TICK) begin
            for (int i = 0; i < NUM; i++) begin
                if (tbl_valid[i]) begin
                    if (tbl_timer[i] <= 16'd1) begin
                        tbl_valid[i] = 1'b0;
                        tbl_group[i] = '0;
                        tbl_port[i]  = '0;
                        tbl_timer[i] = '0;
                        if (r.expired != EXP_MAX) r.expired = r.expired + 6'd1;
                    end else begin
                        tbl_timer[i] = tbl_timer[i] - 16'd1;
                    end
                end
            end
        end else begin
            for (int i = 0; i < NUM; i++) begin
                if (hit < 0 && tbl_valid[i] && tbl_port[i] == port && tbl_group[i] == grp)
                    hit = i;
            end
            r.member = (hit >= 0);
            case (op)
                OP_JOIN: begin
                    if (hit >= 0) begin
                        tbl_timer[hit] = tbl_lifetime;
                        r.status = ST_MATCH;
                    end else begin
                        r.status = ST_FULL;
                        for (int i = 0; i < NUM; i++) begin
                            if (!placed && !tbl_valid[i]) begin
                                tbl_valid[i] = 1'b1;
                                tbl_group[i] = grp;
                                tbl_port[i]  = port;
                                tbl_timer[i] = tbl_lifetime;
                                r.status = ST_ADDED;
                                placed = 1'b1;
                            end
                        end
                    end
                end
                OP_LEAVE: begin
                    if (hit >= 0) begin
                        tbl_valid[hit] = 1'b0;
                        tbl_group[hit] = '0;
                        tbl_port[hit]  = '0;
                        tbl_timer[hit] = '0;
                        r.status = ST_REMOVED;
                    end else begin
                        r.status = ST_NOMATCH;
                    end
                end
                default: begin
                    r.status = (hit >= 0) ? ST_MATCH : ST_NOMATCH;
                end
            endcase
        end
        return r;
    endfunction

    // push stays high after acceptance; wait_drain or the next idle gap lowers it
    task automatic send_item(t_op op, logic [3:0] port, logic [31:0] grp);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_func <= op;
        i_port <= port;
        i_group_addr <= grp;
        do @(posedge i_clk); while (full);
        pending_results.push_back(table_update(op, port, grp));
    endtask

    task automatic wait_drain();
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (NUM + 3) @(posedge i_clk);
    endtask

    // write one register, then read back the lifetime
    task automatic set_lifetime(logic [ADDR_W-1:0] addr, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_LIFETIME) tbl_lifetime = data[15:0];
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= ADDR_LIFETIME;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[15:0] !== tbl_lifetime) begin
            $error("group_lifetime: expected %0d, actual %0d", tbl_lifetime, prdata[15:0]);
            err_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic reconfigure(logic [15:0] life);
        wait_drain();
        set_lifetime(ADDR_LIFETIME, {16'($urandom), life});
    endtask

    task automatic traffic_burst(int n, int jw, int lw, int kw, int tw, int pool_n);
        int   r;
        int   k;
        t_op  op;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(jw + lw + kw + tw - 1);
            if (r < jw) op = OP_JOIN;
            else if (r < jw + lw) op = OP_LEAVE;
            else if (r < jw + lw + kw) op = OP_LOOKUP;
            else op = OP_TICK;
            if (op != OP_TICK && $urandom_range(99) < 85) begin
                k = $urandom_range(pool_n - 1);
                send_item(op, pool_port[k], pool_grp[k]);
            end else begin
                send_item(op, 4'($urandom), $urandom);
            end
        end
    endtask

    task automatic test_basic_ops();
        send_item(OP_JOIN, 4'd0, 32'h0);
        send_item(OP_JOIN, 4'd0, 32'h0);
        send_item(OP_JOIN, 4'd15, 32'hFFFF_FFFF);
        send_item(OP_LOOKUP, 4'd15, 32'hFFFF_FFFF);
        send_item(OP_LOOKUP, 4'd14, 32'hFFFF_FFFF);
        send_item(OP_LEAVE, 4'd15, 32'hFFFF_FFFF);
        send_item(OP_LEAVE, 4'd15, 32'hFFFF_FFFF);
        send_item(OP_LOOKUP, 4'd0, 32'h0);
        send_item(OP_TICK, 4'($urandom), $urandom);
        send_item(OP_LEAVE, 4'd0, 32'h0);
    endtask

    task automatic test_short_lifetimes();
        // write to an unmapped address must leave the lifetime at its reset value
        wait_drain();
        set_lifetime(ADDR_SPARE, $urandom);
        reconfigure(16'd0);
        send_item(OP_JOIN, 4'd5, 32'hE000_0001);
        send_item(OP_TICK, 4'($urandom), $urandom);
        reconfigure(16'd1);
        send_item(OP_JOIN, 4'd5, 32'hE000_0001);
        send_item(OP_JOIN, 4'd6, 32'hE000_0001);
        send_item(OP_TICK, 4'($urandom), $urandom);
        // lookup must not refresh the timer
        reconfigure(16'd2);
        send_item(OP_JOIN, 4'd7, 32'hEFFF_FFFA);
        send_item(OP_LOOKUP, 4'd7, 32'hEFFF_FFFA);
        send_item(OP_TICK, 4'($urandom), $urandom);
        send_item(OP_LOOKUP, 4'd7, 32'hEFFF_FFFA);
        send_item(OP_TICK, 4'($urandom), $urandom);
    endtask

    task automatic test_table_full();
        reconfigure(16'hFFFF);
        for (int i = 0; i <= NUM; i++) send_item(OP_JOIN, pool_port[i], pool_grp[i]);
        send_item(OP_LOOKUP, pool_port[NUM], pool_grp[NUM]);
        for (int i = 0; i < NUM; i++) send_item(OP_LEAVE, pool_port[i], pool_grp[i]);
    endtask

    task automatic test_random_traffic(int send_pct, int stall_pct, logic [15:0] life_c);
        send_idle_pct = send_pct;
        pop_stall_pct = stall_pct;
        reconfigure(16'($urandom_range(2, 12)));
        traffic_burst(150, 40, 15, 25, 20, 8);
        reconfigure(16'($urandom_range(20, 60)));
        traffic_burst(150, 55, 5, 20, 20, POOL_N);
        reconfigure(life_c);
        traffic_burst(140, 35, 20, 25, 20, 16);
    endtask

    task automatic test_backpressure();
        reconfigure(16'd50);
        send_idle_pct = 0;
        pop_stall_pct = 0;
        hold_left = 400;
        traffic_burst(40, 40, 15, 30, 15, 8);
    endtask

    // result side: random pop stalls, long hold-off on request, transaction check
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected transaction: member %0d status %0d expired %0d",
                           o_member, o_status, o_expired);
                    err_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_member !== want.member) begin
                        $error("member: expected %0d, actual %0d", want.member, o_member);
                        err_count++;
                    end
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, o_status);
                        err_count++;
                    end
                    if (o_expired !== want.expired) begin
                        $error("expired: expected %0d, actual %0d", want.expired, o_expired);
                        err_count++;
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left = hold_left - 1;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= pop_stall_pct);
            end
        end
    end

    initial begin
        for (int i = 0; i < POOL_N; i++) begin
            pool_port[i] = 4'(i);
            pool_grp[i] = {26'($urandom), 6'(i)};
        end
        pool_grp[0] = 32'h0;
        pool_grp[POOL_N-1] = 32'hFFFF_FFFF;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_basic_ops();
        test_short_lifetimes();
        test_table_full();
        test_random_traffic(25, 84, 16'hFFFF);
        test_random_traffic(84, 25, 16'd1);
        test_random_traffic(0, 0, 16'($urandom_range(1, 65535)));
        test_backpressure();
        wait_drain();
        if (err_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
